[rtl/rwcp_pkg.sv]
// Shared types and constants of the RIFF/WAVE chunk parser.
package rwcp_pkg;

  typedef enum logic [2:0] {
    PH_FILE,
    PH_HDR,
    PH_BODY,
    PH_PAD,
    PH_BAD
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] RIFF_TAG_LAST = 32'd3;
  localparam logic [31:0] FILE_HDR_LAST = 32'd11;
  localparam logic [31:0] CHUNK_TAG_LEN = 32'd4;
  localparam logic [31:0] CHUNK_HDR_LAST = 32'd7;
  localparam logic [31:0] FMT_MIN = 32'd16;
  localparam logic [31:0] FMT_EXT = 32'd18;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_HDR  = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] avg_byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [15:0] extra_size;
  } fmt_t;

  // One queue entry: a sample, a final report, or a sample followed by the report.
  typedef struct packed {
    logic        has_sample;
    logic        has_report;
    logic [7:0]  sample_byte;
    logic        new_data_chunk;
    logic [1:0]  status;
    fmt_t        fmt;
  } cmd_t;

endpackage

[rtl/rwcp_channels.sv]
// Valid/ready channel interfaces for the byte stream and the result stream.
interface rwcp_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface rwcp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  sample_byte;
  logic        new_data_chunk;
  logic [1:0]  status;
  logic [15:0] format_tag;
  logic [15:0] channels;
  logic [31:0] sample_rate;
  logic [31:0] avg_byte_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;
  logic [15:0] extra_size;

  modport source (
    output valid, output kind, output sample_byte, output new_data_chunk, output status,
    output format_tag, output channels, output sample_rate, output avg_byte_rate,
    output block_align, output bits_per_sample, output extra_size, input ready
  );
  modport sink (
    input valid, input kind, input sample_byte, input new_data_chunk, input status,
    input format_tag, input channels, input sample_rate, input avg_byte_rate,
    input block_align, input bits_per_sample, input extra_size, output ready
  );
endinterface

[rtl/rwcp_front.sv]
// Front end: accepts file bytes, tracks the RIFF chunk structure, queues results.
module rwcp_front (
  input  logic              clk,
  input  logic              rst,
  rwcp_stream_if.sink       stream,
  input  logic              q_full,
  output logic              push,
  output rwcp_pkg::cmd_t    push_cmd
);
  import rwcp_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [31:0] tag, tag_next;
  logic [31:0] len, len_next;
  fmt_t        fmt, fmt_next;
  logic        fmt_seen, fmt_seen_next;
  logic        samp_seen, samp_seen_next;
  logic        hdr_bad, hdr_bad_next;

  logic        accept;
  logic [31:0] tag_v;
  logic [31:0] len_v;
  logic [31:0] pos_inc;
  logic        body_end;
  logic        fmt_cap;
  logic [7:0]  b;
  logic [1:0]  st;

  assign stream.ready = !q_full;
  assign accept       = stream.valid && stream.ready;
  assign b            = stream.file_byte;

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    tag_next       = tag;
    len_next       = len;
    fmt_next       = fmt;
    fmt_seen_next  = fmt_seen;
    samp_seen_next = samp_seen;
    hdr_bad_next   = hdr_bad;
    push_cmd       = '0;
    st             = ST_OK;

    tag_v    = {b, tag[31:8]};
    len_v    = {b, len[31:8]};
    pos_inc  = pos + 32'd1;
    body_end = ({1'b0, pos} + 33'd1) >= {1'b0, len};
    fmt_cap  = (tag == TAG_FMT) && (len >= FMT_MIN);

    if (accept) begin
      unique case (phase)
        PH_FILE: begin
          tag_next = tag_v;
          if (pos == RIFF_TAG_LAST && tag_v != TAG_RIFF) hdr_bad_next = 1'b1;
          if (pos == FILE_HDR_LAST) begin
            if (tag_v != TAG_WAVE) hdr_bad_next = 1'b1;
            phase_next = hdr_bad_next ? PH_BAD : PH_HDR;
            pos_next   = '0;
            tag_next   = '0;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_HDR: begin
          if (pos < CHUNK_TAG_LEN) tag_next = tag_v;
          else len_next = len_v;
          if (pos == CHUNK_HDR_LAST) begin
            if (tag_next == TAG_FMT && len_next >= FMT_MIN) begin
              fmt_seen_next = 1'b1;
              if (len_next < FMT_EXT) fmt_next.extra_size = '0;
            end else if (tag_next == TAG_DATA) begin
              samp_seen_next = (len_next != 32'd0);
            end
            pos_next   = '0;
            // an empty chunk has an even size, so no pad byte follows
            phase_next = (len_next != 32'd0) ? PH_BODY : PH_HDR;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_BODY: begin
          if (fmt_cap) begin
            if (pos[31:5] == '0) begin
              unique case (pos[4:0])
                5'd0:  fmt_next.format_tag[7:0]       = b;
                5'd1:  fmt_next.format_tag[15:8]      = b;
                5'd2:  fmt_next.channels[7:0]         = b;
                5'd3:  fmt_next.channels[15:8]        = b;
                5'd4:  fmt_next.sample_rate[7:0]      = b;
                5'd5:  fmt_next.sample_rate[15:8]     = b;
                5'd6:  fmt_next.sample_rate[23:16]    = b;
                5'd7:  fmt_next.sample_rate[31:24]    = b;
                5'd8:  fmt_next.avg_byte_rate[7:0]    = b;
                5'd9:  fmt_next.avg_byte_rate[15:8]   = b;
                5'd10: fmt_next.avg_byte_rate[23:16]  = b;
                5'd11: fmt_next.avg_byte_rate[31:24]  = b;
                5'd12: fmt_next.block_align[7:0]      = b;
                5'd13: fmt_next.block_align[15:8]     = b;
                5'd14: fmt_next.bits_per_sample[7:0]  = b;
                5'd15: fmt_next.bits_per_sample[15:8] = b;
                5'd16: if (len >= FMT_EXT) fmt_next.extra_size[7:0]  = b;
                5'd17: if (len >= FMT_EXT) fmt_next.extra_size[15:8] = b;
                default: ;
              endcase
            end
          end else if (tag == TAG_DATA) begin
            push_cmd.has_sample     = 1'b1;
            push_cmd.sample_byte    = b;
            push_cmd.new_data_chunk = (pos == 32'd0);
          end
          if (body_end) begin
            pos_next   = '0;
            phase_next = len[0] ? PH_PAD : PH_HDR;
          end else begin
            pos_next = pos_inc;
          end
        end
        PH_PAD: begin
          pos_next   = '0;
          phase_next = PH_HDR;
        end
        PH_BAD: ;
        default: ;
      endcase

      if (stream.end_of_file) begin
        priority if (phase_next == PH_FILE || phase_next == PH_BAD) st = ST_BAD_HDR;
        else if (phase_next == PH_BODY)                               st = ST_OVERRUN;
        else if (!(fmt_seen_next && samp_seen_next))                  st = ST_MISSING;
        else                                                          st = ST_OK;
        push_cmd.has_report = 1'b1;
        push_cmd.status     = st;
        push_cmd.fmt        = (st == ST_OK) ? fmt_next : '0;
        // return to the start of a new file
        phase_next     = PH_FILE;
        pos_next       = '0;
        tag_next       = '0;
        len_next       = '0;
        fmt_next       = '0;
        fmt_seen_next  = 1'b0;
        samp_seen_next = 1'b0;
        hdr_bad_next   = 1'b0;
      end
    end
  end

  assign push = push_cmd.has_sample || push_cmd.has_report;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FILE;
      pos       <= '0;
      tag       <= '0;
      len       <= '0;
      fmt       <= '0;
      fmt_seen  <= 1'b0;
      samp_seen <= 1'b0;
      hdr_bad   <= 1'b0;
    end else begin
      phase     <= phase_next;
      pos       <= pos_next;
      tag       <= tag_next;
      len       <= len_next;
      fmt       <= fmt_next;
      fmt_seen  <= fmt_seen_next;
      samp_seen <= samp_seen_next;
      hdr_bad   <= hdr_bad_next;
    end
  end

endmodule

[rtl/rwcp_queue.sv]
// Short FIFO of parsed commands between the front end and the result stage.
module rwcp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rwcp_pkg::cmd_t  push_cmd,
  output logic            full,
  output logic            head_valid,
  output rwcp_pkg::cmd_t  head_cmd,
  input  logic            pop
);
  import rwcp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

[rtl/rwcp_back.sv]
// Result stage: turns queued commands into sample and report transactions.
module rwcp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  rwcp_pkg::cmd_t  head_cmd,
  output logic            pop,
  rwcp_result_if.source   result
);
  import rwcp_pkg::*;

  logic       out_valid;
  logic       kind;
  logic [7:0] sample_byte;
  logic       new_data_chunk;
  logic [1:0] status;
  fmt_t       fmt;
  logic       sample_done;

  logic       load;
  logic       emit_sample;

  assign load        = head_valid && (!out_valid || result.ready);
  assign emit_sample = head_cmd.has_sample && !sample_done;
  // hold the entry for one more transaction when the report still follows the sample
  assign pop         = load && !(emit_sample && head_cmd.has_report);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      sample_done <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      if (load) sample_done <= emit_sample && head_cmd.has_report;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_sample) begin
        kind           <= KIND_SAMPLE;
        sample_byte    <= head_cmd.sample_byte;
        new_data_chunk <= head_cmd.new_data_chunk;
        status         <= ST_OK;
        fmt            <= '0;
      end else begin
        kind           <= KIND_REPORT;
        sample_byte    <= '0;
        new_data_chunk <= 1'b0;
        status         <= head_cmd.status;
        fmt            <= head_cmd.fmt;
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.kind            = kind;
  assign result.sample_byte     = sample_byte;
  assign result.new_data_chunk  = new_data_chunk;
  assign result.status          = status;
  assign result.format_tag      = fmt.format_tag;
  assign result.channels        = fmt.channels;
  assign result.sample_rate     = fmt.sample_rate;
  assign result.avg_byte_rate   = fmt.avg_byte_rate;
  assign result.block_align     = fmt.block_align;
  assign result.bits_per_sample = fmt.bits_per_sample;
  assign result.extra_size      = fmt.extra_size;

endmodule

[rtl/riff_wave_chunk_parser.sv]
// Top level of the RIFF/WAVE chunk parser: front end, command queue and result stage.
//
//   channel   role    payload
//   stream    sink    file_byte, end_of_file
//   result    source  kind, sample_byte, new_data_chunk, status, format fields
//
// One byte is taken per cycle while the command queue has room; the front end updates its
// chunk state in that cycle. A data byte that ends the file yields two transactions, sample
// then report, from one queue entry. Results pass through the queue and an output register.
// Bytes are taken while the command queue (QUEUE_DEPTH entries) has room, so the
// input stalls only after that many results pile up behind a stalled output.
// Reset is synchronous and returns the parser to the start of a file.
module riff_wave_chunk_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  rwcp_stream_if.sink   stream,
  rwcp_result_if.source result
);
  import rwcp_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  rwcp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .stream   (stream),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rwcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  rwcp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .result     (result)
  );

endmodule

[rtl/rwcp_checker.sv]
// Port-level checks on the result stream of the chunk parser, bound to the top level.
module rwcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        kind,
  input logic [7:0]  sample_byte,
  input logic        new_data_chunk,
  input logic [1:0]  status,
  input logic [15:0] format_tag,
  input logic [15:0] channels,
  input logic [31:0] sample_rate,
  input logic [31:0] avg_byte_rate,
  input logic [15:0] block_align,
  input logic [15:0] bits_per_sample,
  input logic [15:0] extra_size
);
  import rwcp_pkg::*;

  logic fmt_zero;
  assign fmt_zero = (format_tag == '0) && (channels == '0) && (sample_rate == '0) &&
                    (avg_byte_rate == '0) && (block_align == '0) &&
                    (bits_per_sample == '0) && (extra_size == '0);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(kind) && $stable(sample_byte) &&
      $stable(status) && $stable(format_tag))
    else $error("stalled result changed");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_SAMPLE |-> status == ST_OK && fmt_zero)
    else $error("sample transaction carries report fields");

  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_REPORT |-> sample_byte == '0 && !new_data_chunk &&
      (status == ST_OK || fmt_zero))
    else $error("report transaction carries stray fields");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !valid)
    else $error("result valid right after reset");

endmodule

bind riff_wave_chunk_parser rwcp_checker u_rwcp_checker (
  .clk             (clk),
  .rst             (rst),
  .valid           (result.valid),
  .ready           (result.ready),
  .kind            (result.kind),
  .sample_byte     (result.sample_byte),
  .new_data_chunk  (result.new_data_chunk),
  .status          (result.status),
  .format_tag      (result.format_tag),
  .channels        (result.channels),
  .sample_rate     (result.sample_rate),
  .avg_byte_rate   (result.avg_byte_rate),
  .block_align     (result.block_align),
  .bits_per_sample (result.bits_per_sample),
  .extra_size      (result.extra_size)
);

[bench/rwcp_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard class that predicts the parser's results byte by byte and checks them.
package rwcp_tb_pkg;
  import rwcp_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] sample_byte;
    logic       new_data_chunk;
    logic [1:0] status;
    fmt_t       fmt;
  } wave_result_t;

  class wave_scoreboard;
    phase_t       phase;
    logic [31:0]  pos;
    logic [31:0]  tag;
    logic [31:0]  len;
    fmt_t         saved;
    logic         fmt_seen;
    logic         samples_seen;
    logic         header_bad;
    wave_result_t awaited_results[$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase        = PH_FILE;
      pos          = '0;
      tag          = '0;
      len          = '0;
      saved        = '0;
      fmt_seen     = 1'b0;
      samples_seen = 1'b0;
      header_bad   = 1'b0;
    endfunction

    function void end_chunk();
      pos   = '0;
      phase = len[0] ? PH_PAD : PH_HDR;
    endfunction

    // Advance the parser state by one file byte and queue the results it yields.
    function void note_byte(logic [7:0] b, logic eof);
      wave_result_t r;
      int           p;
      p = 0;
      case (phase)
        PH_FILE: begin
          tag = {b, tag[31:8]};
          if (pos == RIFF_TAG_LAST && tag != TAG_RIFF) header_bad = 1'b1;
          if (pos == FILE_HDR_LAST) begin
            if (tag != TAG_WAVE) header_bad = 1'b1;
            phase = header_bad ? PH_BAD : PH_HDR;
            pos   = '0;
            tag   = '0;
          end else begin
            pos++;
          end
        end
        PH_HDR: begin
          if (pos < CHUNK_TAG_LEN) tag = {b, tag[31:8]};
          else len = {b, len[31:8]};
          if (pos == CHUNK_HDR_LAST) begin
            if (tag == TAG_FMT && len >= FMT_MIN) begin
              fmt_seen = 1'b1;
              if (len < FMT_EXT) saved.extra_size = '0;
            end else if (tag == TAG_DATA) begin
              // an empty data chunk drops the samples seen so far
              samples_seen = (len != 0);
            end
            pos = '0;
            if (len != 0) phase = PH_BODY;
            else end_chunk();
          end else begin
            pos++;
          end
        end
        PH_BODY: begin
          if (tag == TAG_FMT && len >= FMT_MIN) begin
            if (pos < FMT_EXT) begin
              p = int'(pos[4:0]);
              if (p < 2) saved.format_tag[8*p +: 8] = b;
              else if (p < 4) saved.channels[8*(p-2) +: 8] = b;
              else if (p < 8) saved.sample_rate[8*(p-4) +: 8] = b;
              else if (p < 12) saved.avg_byte_rate[8*(p-8) +: 8] = b;
              else if (p < 14) saved.block_align[8*(p-12) +: 8] = b;
              else if (p < 16) saved.bits_per_sample[8*(p-14) +: 8] = b;
              else if (len >= FMT_EXT) saved.extra_size[8*(p-16) +: 8] = b;
            end
          end else if (tag == TAG_DATA) begin
            r                = '0;
            r.kind           = KIND_SAMPLE;
            r.sample_byte    = b;
            r.new_data_chunk = (pos == 0);
            awaited_results  = {awaited_results, r};
          end
          if (({1'b0, pos} + 33'd1) >= {1'b0, len}) end_chunk();
          else pos++;
        end
        PH_PAD: begin
          pos   = '0;
          phase = PH_HDR;
        end
        default: ;
      endcase

      if (eof) begin
        r      = '0;
        r.kind = KIND_REPORT;
        if (phase == PH_FILE || phase == PH_BAD) r.status = ST_BAD_HDR;
        else if (phase == PH_BODY) r.status = ST_OVERRUN;
        else if (!(fmt_seen && samples_seen)) r.status = ST_MISSING;
        else r.status = ST_OK;
        if (r.status == ST_OK) r.fmt = saved;
        awaited_results = {awaited_results, r};
        restart();
      end
    endfunction

    function void check_result(wave_result_t got);
      wave_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d byte %h status %0d",
                   got.kind, got.sample_byte, got.status);
        return;
      end
      want = awaited_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch (exp/act): kind %0d/%0d byte %h/%h new %0d/%0d status %0d/%0d",
                   want.kind, got.kind, want.sample_byte, got.sample_byte,
                   want.new_data_chunk, got.new_data_chunk, want.status, got.status);
          $display("  fmt %h/%h ch %h/%h rate %h/%h avg %h/%h align %h/%h bits %h/%h ext %h/%h",
                   want.fmt.format_tag, got.fmt.format_tag,
                   want.fmt.channels, got.fmt.channels,
                   want.fmt.sample_rate, got.fmt.sample_rate,
                   want.fmt.avg_byte_rate, got.fmt.avg_byte_rate,
                   want.fmt.block_align, got.fmt.block_align,
                   want.fmt.bits_per_sample, got.fmt.bits_per_sample,
                   want.fmt.extra_size, got.fmt.extra_size);
        end
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Top-level testbench of the RIFF/WAVE chunk parser: file generator, drivers and watchdog.
module tb_top;
  import rwcp_pkg::*;
  import rwcp_tb_pkg::*;

  localparam int ITEMS_TARGET   = 1350;
  localparam int CALM_TAIL      = 200;
  localparam int WATCHDOG_LIMIT = 300;
  localparam int DRAIN_CYCLES   = 8;

  logic clk;
  logic rst;

  rwcp_stream_if stream_ch();
  rwcp_result_if result_ch();

  riff_wave_chunk_parser u_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch)
  );

  wave_scoreboard board = new();

  logic [7:0] file_buf[$];
  int         sent_bytes = 0;
  int         gap_odds   = 0;
  bit         calm       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_buf = {file_buf, w[8*i +: 8]};
  endtask

  task push_random_bytes(input int count);
    for (int i = 0; i < count; i++) file_buf = {file_buf, 8'($urandom())};
  endtask

  // Header, random body and pad byte when the size is odd.
  task push_chunk(input logic [31:0] tag, input logic [31:0] len);
    push_word(tag);
    push_word(len);
    push_random_bytes(len);
    if (len[0]) file_buf = {file_buf, 8'($urandom())};
  endtask

  function automatic logic [31:0] fmt_length();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 15);
      1:       return 32'd17;
      2, 3:    return 32'd18;
      4:       return $urandom_range(19, 24);
      default: return 32'd16;
    endcase
  endfunction

  task build_wave_file();
    int pick;
    int n_chunks;
    int cut;
    file_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // short file: ends inside the file header
      push_word(TAG_RIFF);
      push_word($urandom());
      push_word(TAG_WAVE);
      cut = $urandom_range(1, 11);
      while (file_buf.size() > cut) void'(file_buf.pop_back());
    end else if (pick < 14) begin
      push_word(TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)));
      push_word($urandom());
      push_word(TAG_WAVE);
      push_random_bytes($urandom_range(0, 12));
    end else if (pick < 20) begin
      push_word(TAG_RIFF);
      push_word($urandom());
      push_word(TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)));
      push_chunk(TAG_FMT, 32'd16);
      push_chunk(TAG_DATA, $urandom_range(1, 4));
    end else if (pick < 24) begin
      push_random_bytes($urandom_range(1, 24));
    end else begin
      push_word(TAG_RIFF);
      push_word($urandom());
      push_word(TAG_WAVE);
      n_chunks = $urandom_range(1, 4);
      for (int i = 0; i < n_chunks; i++) begin
        if (i == 0 && $urandom_range(0, 9) < 8) push_chunk(TAG_FMT, fmt_length());
        else if (i == n_chunks - 1 && $urandom_range(0, 9) < 8)
          push_chunk(TAG_DATA, $urandom_range(1, 16));
        else begin
          case ($urandom_range(0, 2))
            0:       push_chunk(TAG_FMT, fmt_length());
            1:       push_chunk(TAG_DATA, $urandom_range(0, 16));
            default: push_chunk($urandom(), $urandom_range(0, 9));
          endcase
        end
      end
      case ($urandom_range(0, 9))
        0, 1: push_random_bytes($urandom_range(1, 7));
        2: begin
          // data chunk that claims more bytes than the file holds
          push_word(TAG_DATA);
          push_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom() | 32'h100));
          push_random_bytes($urandom_range(0, 8));
        end
        3: void'(file_buf.pop_back());
        4: begin
          cut = $urandom_range(1, file_buf.size());
          while (file_buf.size() > cut) void'(file_buf.pop_back());
        end
        default: ;
      endcase
    end
  endtask

  task send_byte(input logic [7:0] b, input logic eof);
    if (!calm && gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
      stream_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    stream_ch.valid       <= 1'b1;
    stream_ch.file_byte   <= b;
    stream_ch.end_of_file <= eof;
    do @(posedge clk); while (!stream_ch.ready);
    board.note_byte(b, eof);
    sent_bytes++;
  endtask

  task send_file();
    for (int i = 0; i < file_buf.size(); i++) send_byte(file_buf[i], i == file_buf.size() - 1);
  endtask

  initial begin
    rst                   <= 1'b1;
    stream_ch.valid       <= 1'b0;
    stream_ch.file_byte   <= '0;
    stream_ch.end_of_file <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one-byte file, bare header with no chunks, bad RIFF tag with a trailing byte
    file_buf.delete();
    file_buf = {file_buf, 8'h00};
    send_file();
    file_buf.delete();
    push_word(TAG_RIFF);
    push_word(32'hFFFF_FFFF);
    push_word(TAG_WAVE);
    send_file();
    file_buf.delete();
    push_word(TAG_RIFF ^ 32'h0100_0000);
    push_word(32'h0);
    push_word(TAG_WAVE);
    file_buf = {file_buf, 8'hFF};
    send_file();

    while (sent_bytes < ITEMS_TARGET) begin
      calm     = (sent_bytes >= ITEMS_TARGET - CALM_TAIL);
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      build_wave_file();
      send_file();
    end
    stream_ch.valid <= 1'b0;

    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result sink: check each transaction, stall in random bursts.
  initial begin
    int           hold;
    wave_result_t got;
    hold = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        got.kind                = result_ch.kind;
        got.sample_byte         = result_ch.sample_byte;
        got.new_data_chunk      = result_ch.new_data_chunk;
        got.status              = result_ch.status;
        got.fmt.format_tag      = result_ch.format_tag;
        got.fmt.channels        = result_ch.channels;
        got.fmt.sample_rate     = result_ch.sample_rate;
        got.fmt.avg_byte_rate   = result_ch.avg_byte_rate;
        got.fmt.block_align     = result_ch.block_align;
        got.fmt.bits_per_sample = result_ch.bits_per_sample;
        got.fmt.extra_size      = result_ch.extra_size;
        board.check_result(got);
      end
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        result_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 8) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
